// ===== design/stpa_pkg.sv =====
// ----------------------------------------------------------------------------
// stpa_pkg
// Types and register map constants for the periodic system timer.
// ----------------------------------------------------------------------------
package stpa_pkg;

   // Request function codes.
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   // Register word indexes (byte offset divided by four).
   localparam logic [4:0] ADDR_CONF     = 5'd0;
   localparam logic [4:0] ADDR_OP       = 5'd1;
   localparam logic [4:0] ADDR_LOAD_HI  = 5'd3;
   localparam logic [4:0] ADDR_LOAD_LO  = 5'd4;
   localparam logic [4:0] ADDR_TGT_HI   = 5'd7;
   localparam logic [4:0] ADDR_TGT_LO   = 5'd8;
   localparam logic [4:0] ADDR_TCONF    = 5'd13;
   localparam logic [4:0] ADDR_VAL_HI   = 5'd16;
   localparam logic [4:0] ADDR_VAL_LO   = 5'd17;
   localparam logic [4:0] ADDR_CMP_LOAD = 5'd20;
   localparam logic [4:0] ADDR_CNT_LOAD = 5'd23;
   localparam logic [4:0] ADDR_INT_ENA  = 5'd25;
   localparam logic [4:0] ADDR_INT_RAW  = 5'd26;
   localparam logic [4:0] ADDR_INT_CLR  = 5'd27;
   localparam logic [4:0] ADDR_INT_ST   = 5'd28;

   // Bit positions inside the registers.
   localparam int CTRL_UNIT_EN_BIT  = 30;
   localparam int CTRL_CMP_EN_BIT   = 24;
   localparam int CONF_PERIOD_MD_BIT = 30;
   localparam int OP_UPDATE_BIT     = 30;
   localparam int OP_VALID_BIT      = 29;

   localparam logic [31:0] CTRL_RESET = 32'h4000_0000;

endpackage

// ===== design/system_timer_periodic_alarm.sv =====
// ----------------------------------------------------------------------------
// system_timer_periodic_alarm
// 64-bit timer with one periodic comparator, a counter snapshot and an
// interrupt, driven by a stream of tick, read and write words.
// ----------------------------------------------------------------------------
// Each request word is a counter tick, a register read, a register write or a
// no-op, and each one yields exactly one response word carrying the read data
// (zero for ticks, writes and no-ops) and the interrupt line as it stands after
// the request. The block takes one request word per cycle while its output
// register is not stalled: the request is executed against the timer state in
// the cycle it is accepted and its response is captured in an output register.
// The path that sets the rate is the 64-bit counter increment followed by the
// 64-bit alarm compare and alarm advance. A new request is accepted whenever
// the output register is empty or its word is being taken in the same cycle,
// so a stalled response holds the request side only until it is drained.
// PERIOD_BITS sets the width of the comparator period (8 to 32 bits).
module system_timer_periodic_alarm #(
   parameter int PERIOD_BITS = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stpa_pkg::func_type req_func,
   input  logic [4:0]         req_addr,
   input  logic [31:0]        req_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_rdata,
   output logic               rsp_irq
);
   import stpa_pkg::*;

   // Architectural state.
   logic [31:0]            ctrl_ff, ctrl_in;
   logic [63:0]            count_ff, count_in;
   logic [63:0]            snap_ff, snap_in;
   logic                   snap_valid_ff, snap_valid_in;
   logic [63:0]            load_ff, load_in;
   logic [63:0]            target_ff, target_in;
   logic [31:0]            tconf_ff, tconf_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   period_mode_ff, period_mode_in;
   logic [63:0]            alarm_ff, alarm_in;
   logic                   int_ena_ff, int_ena_in;
   logic                   int_raw_ff, int_raw_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_rdata_ff, rsp_rdata_in;
   logic                   rsp_irq_ff, rsp_irq_in;

   logic                   accept;
   logic [31:0]            rdata;
   logic [63:0]            count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign count_inc = count_ff + 64'd1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;
   assign rsp_irq   = rsp_irq_ff;

   always_comb begin
      ctrl_in        = ctrl_ff;
      count_in       = count_ff;
      snap_in        = snap_ff;
      snap_valid_in  = snap_valid_ff;
      load_in        = load_ff;
      target_in      = target_ff;
      tconf_in       = tconf_ff;
      period_in      = period_ff;
      period_mode_in = period_mode_ff;
      alarm_in       = alarm_ff;
      int_ena_in     = int_ena_ff;
      int_raw_in     = int_raw_ff;
      rdata          = 32'd0;

      if (accept) begin
         case (req_func)
            FUNC_TICK: begin
               // The compare runs only on a tick that advances the counter.
               if (ctrl_ff[CTRL_UNIT_EN_BIT]) begin
                  count_in = count_inc;
                  if (ctrl_ff[CTRL_CMP_EN_BIT] && period_mode_ff &&
                      count_inc == alarm_ff) begin
                     int_raw_in = 1'b1;
                     alarm_in   = alarm_ff + {{(64-PERIOD_BITS){1'b0}}, period_ff};
                  end
               end
            end
            FUNC_READ: begin
               case (req_addr)
                  ADDR_CONF:    rdata = ctrl_ff;
                  ADDR_OP:      rdata = {2'b00, snap_valid_ff, 29'd0};
                  ADDR_LOAD_HI: rdata = load_ff[63:32];
                  ADDR_LOAD_LO: rdata = load_ff[31:0];
                  ADDR_TGT_HI:  rdata = target_ff[63:32];
                  ADDR_TGT_LO:  rdata = target_ff[31:0];
                  ADDR_TCONF:   rdata = tconf_ff;
                  ADDR_VAL_HI:  rdata = snap_ff[63:32];
                  ADDR_VAL_LO:  rdata = snap_ff[31:0];
                  ADDR_INT_ENA: rdata = {31'd0, int_ena_ff};
                  ADDR_INT_RAW: rdata = {31'd0, int_raw_ff};
                  ADDR_INT_ST:  rdata = {31'd0, int_raw_ff & int_ena_ff};
                  default:      rdata = 32'd0;
               endcase
            end
            FUNC_WRITE: begin
               case (req_addr)
                  ADDR_CONF: ctrl_in = req_wdata;
                  ADDR_OP: begin
                     if (req_wdata[OP_UPDATE_BIT]) begin
                        snap_in       = count_ff;
                        snap_valid_in = 1'b1;
                     end
                  end
                  ADDR_LOAD_HI: load_in[63:32]   = req_wdata;
                  ADDR_LOAD_LO: load_in[31:0]    = req_wdata;
                  ADDR_TGT_HI:  target_in[63:32] = req_wdata;
                  ADDR_TGT_LO:  target_in[31:0]  = req_wdata;
                  ADDR_TCONF:   tconf_in         = req_wdata;
                  ADDR_CMP_LOAD: begin
                     // Move the staged setup into use and arm one period ahead.
                     if (req_wdata[0]) begin
                        period_in      = tconf_ff[PERIOD_BITS-1:0];
                        period_mode_in = tconf_ff[CONF_PERIOD_MD_BIT];
                        alarm_in       = count_ff +
                           {{(64-PERIOD_BITS){1'b0}}, tconf_ff[PERIOD_BITS-1:0]};
                     end
                  end
                  ADDR_CNT_LOAD: begin
                     if (req_wdata[0]) begin
                        count_in = load_ff;
                     end
                  end
                  ADDR_INT_ENA: int_ena_in = req_wdata[0];
                  ADDR_INT_CLR: begin
                     if (req_wdata[0]) begin
                        int_raw_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      // Output register: load on accept, drain when taken.
      rsp_valid_in = rsp_valid_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_irq_in   = rsp_irq_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_rdata_in = rdata;
         rsp_irq_in   = int_raw_in & int_ena_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff        <= CTRL_RESET;
         count_ff       <= 64'd0;
         snap_ff        <= 64'd0;
         snap_valid_ff  <= 1'b0;
         load_ff        <= 64'd0;
         target_ff      <= 64'd0;
         tconf_ff       <= 32'd0;
         period_ff      <= '0;
         period_mode_ff <= 1'b0;
         alarm_ff       <= 64'd0;
         int_ena_ff     <= 1'b0;
         int_raw_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ctrl_ff        <= ctrl_in;
         count_ff       <= count_in;
         snap_ff        <= snap_in;
         snap_valid_ff  <= snap_valid_in;
         load_ff        <= load_in;
         target_ff      <= target_in;
         tconf_ff       <= tconf_in;
         period_ff      <= period_in;
         period_mode_ff <= period_mode_in;
         alarm_ff       <= alarm_in;
         int_ena_ff     <= int_ena_in;
         int_raw_ff     <= int_raw_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_irq_ff   <= rsp_irq_in;
   end

endmodule
